[src/gss_pkg.sv]
// shared types and constants for the gauss-seidel solver
`default_nettype none
package gss_pkg;
  localparam int MAX_UNKNOWNS = 16;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [4:0]  col_index;
    logic signed [31:0] coef_value;
    logic        start_solve;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  unknown_index;
    logic signed [31:0] solution_value;
    logic [1:0]  status;
    logic [16:0] sweep_count;
    logic        last_result;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_EPSILON     = 2'd0,
    REG_SWEEP_LIMIT = 2'd1,
    REG_SIZE        = 2'd2
  } reg_idx_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LIMIT   = 2'd1;
  localparam logic [1:0] ST_ZERODIAG = 2'd2;

  localparam logic signed [63:0] LIM64 = 64'sh7FFF_FFFF_FFFF_FFFF;
endpackage
`default_nettype wire

[src/gss_div.sv]
// iterative signed divider, 64 by 32 bits, one quotient bit per cycle
`default_nettype none
module gss_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire logic signed [63:0] num,
  input  wire logic signed [31:0] den,
  output logic             done,
  output logic signed [63:0] quo
);
  logic [63:0] q;
  logic [64:0] rem;
  logic [31:0] dmag;
  logic        neg;
  logic [6:0]  cnt;
  logic        run;
  logic [64:0] trial;

  always_comb trial = {rem[63:0], q[63]} - {33'd0, dmag};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      q    <= num[63] ? 64'(-num) : num;
      dmag <= den[31] ? 32'(-den) : den;
      neg  <= num[63] ^ den[31];
      rem  <= '0;
      cnt  <= 7'd64;
      run  <= 1'b1;
    end else if (run) begin
      if (!trial[64]) begin
        rem <= trial;
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[63:0], q[63]};
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = neg ? 64'(-q) : q;
endmodule
`default_nettype wire

[src/gauss_seidel_solver_top.sv]
// top level of the gauss-seidel solver
//
// channel   direction  handshake                 payload
// command   in         start & !busy             in_item  (gss_pkg::in_item_t)
// result    out        result_valid, no stall    result   (gss_pkg::out_item_t)
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// a load transaction writes one item while idle; a solve first checks the diagonal
// of every row, then each sweep saves x, then for every row runs each coefficient
// on the shared multiplier, the row setup and the 64-bit serial divider, then
// forms the distance over every unknown and ends with a test
// results leave one per cycle (n of them, or one status) and cannot be held off
// rst is synchronous; stores are undefined until written
`default_nettype none
module gauss_seidel_solver_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire gss_pkg::in_item_t in_item,
  output logic      result_valid,
  output gss_pkg::out_item_t result,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int MAX_UNKNOWNS = gss_pkg::MAX_UNKNOWNS;
  localparam int IW = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
  localparam int NW = $clog2(MAX_UNKNOWNS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIAG_RD, S_DIAG_CHK, S_INIT, S_ROW, S_MAC_RD, S_MAC, S_DIV,
    S_DIV_WAIT, S_NORM, S_CHECK, S_EMIT, S_STATUS
  } state_t;

  state_t state;
  // configuration registers
  logic [30:0] epsilon;
  logic [15:0] sweep_limit;
  logic [4:0]  size_in_use;

  // storage
  logic signed [31:0] coef_mem [MAX_UNKNOWNS*MAX_UNKNOWNS];
  logic signed [31:0] rhs_mem  [MAX_UNKNOWNS];
  logic signed [31:0] x_mem    [MAX_UNKNOWNS];
  logic signed [31:0] prev_mem [MAX_UNKNOWNS];
  logic signed [31:0] coef_rd;

  logic [NW-1:0] n;
  logic [IW-1:0] i, j;
  logic signed [63:0] num;
  logic signed [63:0] prod;
  logic signed [31:0] diag;
  logic [63:0] acc;
  logic [16:0] sweep_counter;
  logic [63:0] eps2;
  logic        mul_phase;

  logic        div_go, div_done;
  logic signed [63:0] div_q;

  // effective size
  always_comb begin
    if (size_in_use == 5'd0) n = NW'(1);
    else if (32'(size_in_use) > MAX_UNKNOWNS) n = NW'(MAX_UNKNOWNS);
    else n = NW'(size_in_use);
  end

  assign cfg_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  gss_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(num), .den(diag),
    .done(div_done), .quo(div_q)
  );

  // saturating subtract of one product
  function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                 logic signed [63:0] p);
    logic signed [64:0] r;
    r = 65'(a) - 65'(p);
    if (r < -65'sh7FFF_FFFF_FFFF_FFFF) return -gss_pkg::LIM64;
    if (r > 65'sh7FFF_FFFF_FFFF_FFFF) return gss_pkg::LIM64;
    return r[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // sweep difference of one unknown; its square is at most (2^32-1)^2
  logic signed [32:0] d;
  logic [63:0] sq;
  logic [64:0] acc_sum;
  always_comb d = 33'(x_mem[i]) - 33'(prev_mem[i]);
  always_comb acc_sum = 65'(acc) + 65'(sq);

  // the one shared multiplier: a_ij * x_j, the squared difference, epsilon squared
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  always_comb begin
    unique case (state)
      S_MAC: begin
        mul_a = 33'(coef_rd);
        mul_b = 33'(x_mem[j]);
      end
      S_NORM: begin
        mul_a = d;
        mul_b = d;
      end
      default: begin
        mul_a = {2'b00, epsilon};
        mul_b = {2'b00, epsilon};
      end
    endcase
    mul_p = 66'(mul_a) * 66'(mul_b);
  end

  logic [IW+IW-1:0] wr_addr;
  assign wr_addr = {in_item.row_index[IW-1:0], in_item.col_index[IW-1:0]};

  // coefficient memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && 32'(in_item.row_index) < MAX_UNKNOWNS
        && NW'(in_item.col_index) < n && 32'(in_item.col_index) < MAX_UNKNOWNS)
      coef_mem[wr_addr] <= in_item.coef_value;
    coef_rd <= coef_mem[{i, j}];
  end

  always_ff @(posedge clk) begin
    div_go <= 1'b0;
    result_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      epsilon <= 31'd66;
      sweep_limit <= 16'd1000;
      size_in_use <= 5'd16;
      acc <= '0;
      sweep_counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              gss_pkg::REG_EPSILON:     epsilon <= cfg_data[30:0];
              gss_pkg::REG_SWEEP_LIMIT: sweep_limit <= cfg_data[15:0];
              gss_pkg::REG_SIZE:        size_in_use <= cfg_data[4:0];
              default: ;
            endcase
          end
          if (start) begin
            if (32'(in_item.row_index) < MAX_UNKNOWNS
                && NW'(in_item.col_index) == n)
              rhs_mem[in_item.row_index[IW-1:0]] <= in_item.coef_value;
            if (in_item.start_solve) begin
              sweep_counter <= '0;
              acc <= '0;
              eps2 <= mul_p[63:0];
              i <= '0;
              j <= '0;
              state <= S_DIAG_RD;
            end
          end
        end
        S_DIAG_RD: state <= S_DIAG_CHK; // read of a_ii in flight
        S_DIAG_CHK: begin
          if (coef_rd == 32'sd0) state <= S_STATUS;
          else begin
            x_mem[i] <= rhs_mem[i];
            if (NW'(i) == n - NW'(1)) begin
              i <= '0;
              state <= S_INIT;
            end else begin
              i <= i + IW'(1);
              j <= i + IW'(1);
              state <= S_DIAG_RD;
            end
          end
        end
        S_INIT: begin
          // new sweep: keep copy of x
          for (int k = 0; k < MAX_UNKNOWNS; k++) prev_mem[k] <= x_mem[k];
          i <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          num <= 64'(rhs_mem[i]) <<< 16;
          j <= '0;
          mul_phase <= 1'b0;
          state <= S_MAC_RD;
        end
        S_MAC_RD: state <= S_MAC;
        S_MAC: begin
          // shared multiplier: product registered, then subtract
          if (!mul_phase) begin
            prod <= mul_p[63:0];
            if (j == i) diag <= coef_rd;
            mul_phase <= 1'b1;
          end else begin
            mul_phase <= 1'b0;
            if (j != i) num <= sat_sub(num, prod);
            if (NW'(j) == n - NW'(1)) begin
              state <= S_DIV;
            end else begin
              j <= j + IW'(1);
              state <= S_MAC_RD;
            end
          end
        end
        S_DIV: begin
          div_go <= 1'b1;
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            x_mem[i] <= sat32(div_q);
            if (NW'(i) == n - NW'(1)) begin
              i <= '0;
              acc <= '0;
              sweep_counter <= sweep_counter + 17'd1;
              state <= S_NORM;
            end else begin
              i <= i + IW'(1);
              state <= S_ROW;
            end
          end
        end
        S_NORM: begin
          // square registered, then saturating accumulate
          if (!mul_phase) begin
            sq <= mul_p[63:0];
            mul_phase <= 1'b1;
          end else begin
            mul_phase <= 1'b0;
            acc <= acc_sum[64] ? '1 : acc_sum[63:0];
            if (NW'(i) == n - NW'(1)) state <= S_CHECK;
            else i <= i + IW'(1);
          end
        end
        S_CHECK: begin
          i <= '0;
          if (sweep_counter > 17'(sweep_limit)) state <= S_STATUS;
          else if (acc < eps2) state <= S_EMIT;
          else state <= S_INIT;
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          result.unknown_index <= 4'(i);
          result.solution_value <= x_mem[i];
          result.status <= gss_pkg::ST_OK;
          result.sweep_count <= sweep_counter;
          result.last_result <= (NW'(i) == n - NW'(1));
          if (NW'(i) == n - NW'(1)) state <= S_IDLE;
          else i <= i + IW'(1);
        end
        S_STATUS: begin
          result_valid <= 1'b1;
          result.unknown_index <= '0;
          result.solution_value <= '0;
          result.status <= (sweep_counter == '0) ? gss_pkg::ST_ZERODIAG
                                                 : gss_pkg::ST_LIMIT;
          result.sweep_count <= sweep_counter;
          result.last_result <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/gss_checker.sv]
// port-level checker for the solver, bound to the top level
`default_nettype none
module gss_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid,
  input wire gss_pkg::out_item_t result,
  input wire logic cfg_ready
);
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !busy) else $error("cfg ready while busy");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_result |-> busy) else $error("early idle");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != gss_pkg::ST_OK |-> result.last_result)
    else $error("status not last");
  a_rst_idle: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");
endmodule
bind gauss_seidel_solver_top gss_checker u_chk (.*);
`default_nettype wire
